FILE: hw/rtl/byte_word_slot_allocator_defines.svh
// assertion macros for the byte/word slot allocator
`ifndef BYTE_WORD_SLOT_ALLOCATOR_DEFINES_SVH
`define BYTE_WORD_SLOT_ALLOCATOR_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BWSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define BWSA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/bwsa_pkg.sv
// shared types and constants of the byte/word slot allocator
`timescale 1ns / 1ps
package bwsa_pkg;

  localparam int NSLOTS = 32;
  localparam int SLOT_W = 5;                      // slot_index field width
  localparam int PTR_W  = $clog2(NSLOTS + 1);     // scan pointer, reaches NSLOTS
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 6;                      // slot count register width
  localparam int CFG_W  = 16;                     // widest register

  localparam logic CFG_BASE_ADDR  = 1'b0;
  localparam logic CFG_SLOT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_BYTE = 2'd1,
    SLOT_WORD = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_SIZE    = 3'd2,
    ST_SECOND  = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  // table update done when a result is committed
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_SET_BYTE = 3'd1,
    ACT_SET_WORD = 3'd2,
    ACT_CLR_ONE  = 3'd3,
    ACT_CLR_TWO  = 3'd4
  } act_e;

  typedef struct packed {
    logic    load_alloc;
    logic    load_rel;
    logic    step;
    logic    finish;
    act_e    act;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic  in_range;
    slot_e cur;
    logic  prev_free;
    logic  out_free;
  } sts_t;

endpackage

FILE: hw/rtl/byte_word_slot_allocator.sv
// top level of the first-fit byte/word slot allocator
// allocate: result registered when a first-fit scan from slot 0 ends, one slot per scan cycle
// release: result registered after checking one slot for a byte, two slots for a word
// one request is handled at a time; next beat taken the cycle after the result
// is registered, and a stalled result beat holds the sequencer until the output drains
// reset clears the slot table to free, base address to 0 and slot count to 32
`timescale 1ns / 1ps
`include "byte_word_slot_allocator_defines.svh"
module byte_word_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] slot_index, [7:5] zero
  input  logic [1:0]  s_tuser,   // [0] kind, [1] want_word
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] status, [7:3] granted_slot, [23:8] granted_address
  // config writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import bwsa_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  status_e            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [ADDR_W-1:0]  out_addr;
  logic               bad_fields;

  // sequencer: walks the table for allocate, checks one or two slots for release
  bwsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid),
    .req_ready_o (s_tready),
    .req_kind_i  (s_tuser[0]),
    .req_word_i  (s_tuser[1]),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table, pointer and result register; result register decouples the output side
  bwsa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_idx_i    (s_tdata[SLOT_W-1:0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_addr_o   (out_addr)
  );

  assign m_tdata = {out_addr, out_slot, out_status};

  // failed beat showing a slot or an address
  assign bad_fields = m_tvalid && (out_status != ST_OK) && (out_slot != '0 || out_addr != '0);

  // a result is only committed when the output register is empty or draining
  `BWSA_NEVER(a_no_overwrite, cmd.finish && m_tvalid && !m_tready, "result overwritten")

  // failed beats carry zero slot and address
  `BWSA_NEVER(a_zero_fields, bad_fields, "nonzero fields on failed beat")

  // a table update only happens together with an ok status
  `BWSA_NEVER(a_act_ok, cmd.act != ACT_NONE && cmd.status != ST_OK, "table changed on error")

endmodule

FILE: hw/rtl/bwsa_dp.sv
// slot table, scan pointer, config registers and result register
`timescale 1ns / 1ps
module bwsa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bwsa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [bwsa_pkg::SLOT_W-1:0]   req_idx_i,
  input  bwsa_pkg::cmd_t                cmd_i,
  output bwsa_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bwsa_pkg::status_e             out_status_o,
  output logic [bwsa_pkg::SLOT_W-1:0]   out_slot_o,
  output logic [bwsa_pkg::ADDR_W-1:0]   out_addr_o
);
  import bwsa_pkg::*;

  slot_e              table_q [NSLOTS];
  logic [PTR_W-1:0]   ptr_q;
  logic               prev_free_q;
  logic [ADDR_W-1:0]  base_q;
  logic [CNT_W-1:0]   count_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [ADDR_W-1:0]  out_addr_q;

  logic [PTR_W-1:0]   limit;
  logic [SLOT_W-1:0]  cur_idx;
  logic [SLOT_W-1:0]  prv_idx;
  logic [SLOT_W-1:0]  grant_idx;
  logic               grant;
  slot_e              cur;

  assign limit = (PTR_W'(count_q) > PTR_W'(NSLOTS)) ? PTR_W'(NSLOTS) : PTR_W'(count_q);
  assign cur_idx   = ptr_q[SLOT_W-1:0];
  assign prv_idx   = cur_idx - 1'b1;
  assign cur       = table_q[cur_idx];
  assign grant     = (cmd_i.act == ACT_SET_BYTE) || (cmd_i.act == ACT_SET_WORD);
  assign grant_idx = (cmd_i.act == ACT_SET_WORD) ? prv_idx : cur_idx;

  assign sts_o.in_range  = ptr_q < limit;
  assign sts_o.cur       = cur;
  assign sts_o.prev_free = prev_free_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= CNT_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_ADDR:  base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_SLOT_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // slot table, cleared by reset and by a slot count write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOTS; i++) table_q[i] <= SLOT_FREE;
    end else if (cfg_we_i && (cfg_idx_i == CFG_SLOT_COUNT)) begin
      for (int i = 0; i < NSLOTS; i++) table_q[i] <= SLOT_FREE;
    end else if (cmd_i.finish) begin
      case (cmd_i.act)
        ACT_SET_BYTE: table_q[cur_idx] <= SLOT_BYTE;
        ACT_SET_WORD: begin
          table_q[prv_idx] <= SLOT_WORD;
          table_q[cur_idx] <= SLOT_WORD;
        end
        ACT_CLR_ONE: table_q[cur_idx] <= SLOT_FREE;
        ACT_CLR_TWO: begin
          table_q[prv_idx] <= SLOT_FREE;
          table_q[cur_idx] <= SLOT_FREE;
        end
        default: ;
      endcase
    end
  end

  // scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      prev_free_q <= 1'b0;
    end else if (cmd_i.load_alloc) begin
      ptr_q       <= '0;
      prev_free_q <= 1'b0;
    end else if (cmd_i.load_rel) begin
      ptr_q       <= PTR_W'(req_idx_i);
      prev_free_q <= 1'b0;
    end else if (cmd_i.step) begin
      ptr_q       <= ptr_q + 1'b1;
      prev_free_q <= (cur == SLOT_FREE);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= cmd_i.status;
      out_slot_q   <= grant ? grant_idx : '0;
      out_addr_q   <= grant ? (base_q + ADDR_W'(grant_idx)) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_addr_o   = out_addr_q;

endmodule

FILE: hw/rtl/bwsa_ctrl.sv
// request sequencer for allocate scans and release checks
`timescale 1ns / 1ps
module bwsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic           req_kind_i,
  input  logic           req_word_i,
  input  bwsa_pkg::sts_t sts_i,
  output bwsa_pkg::cmd_t cmd_o
);
  import bwsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_REL_FIRST,
    S_REL_SECOND
  } state_e;

  state_e state_q;
  logic   word_q;
  logic   ready_q;
  logic   decide;
  slot_e  want;

  assign want = word_q ? SLOT_WORD : SLOT_BYTE;

  always_comb begin
    cmd_o        = '0;
    cmd_o.act    = ACT_NONE;
    cmd_o.status = ST_OK;
    decide       = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_alloc = req_valid_i && !req_kind_i;
        cmd_o.load_rel   = req_valid_i && req_kind_i;
      end
      S_ALLOC: begin
        if (!sts_i.in_range) begin
          decide       = 1'b1;
          cmd_o.status = ST_NOSPACE;
        end else if (sts_i.cur == SLOT_FREE && (!word_q || sts_i.prev_free)) begin
          decide    = 1'b1;
          cmd_o.act = word_q ? ACT_SET_WORD : ACT_SET_BYTE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_REL_FIRST: begin
        if (!sts_i.in_range) begin
          decide       = 1'b1;
          cmd_o.status = ST_RANGE;
        end else if (sts_i.cur != want) begin
          decide       = 1'b1;
          cmd_o.status = ST_SIZE;
        end else if (!word_q) begin
          decide    = 1'b1;
          cmd_o.act = ACT_CLR_ONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_REL_SECOND: begin
        decide = 1'b1;
        if (!sts_i.in_range) begin
          cmd_o.status = ST_RANGE;
        end else if (sts_i.cur != SLOT_WORD) begin
          cmd_o.status = ST_SECOND;
        end else begin
          cmd_o.act = ACT_CLR_TWO;
        end
      end
      default: ;
    endcase
    // hold the decision until the result register can take it
    cmd_o.finish = decide && sts_i.out_free;
    if (!cmd_o.finish) cmd_o.act = ACT_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      word_q  <= 1'b0;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= req_kind_i ? S_REL_FIRST : S_ALLOC;
            word_q  <= req_word_i;
            ready_q <= 1'b0;
          end
        end
        S_ALLOC: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        S_REL_FIRST: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end else if (cmd_o.step) begin
            state_q <= S_REL_SECOND;
          end
        end
        S_REL_SECOND: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign req_ready_o = ready_q;

endmodule
